@@ src/wst2d_pkg.sv @@
// shared types and constants for the window sum threshold block
// no dependencies; imported by every module of the block
`default_nettype none

package wst2d_pkg;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_CUTOFF = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b1;

  // field widths
  localparam int CUTOFF_W  = 16;
  localparam int WS_W      = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 8;
  localparam int RES_W     = 9;
  localparam int CNT_W     = 16;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = '0;
  localparam logic [WS_W-1:0]     WS_RST     = 3'd1;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // parameter defaults
  localparam int DEF_MATRIX_SIZE = 256;
  localparam int DEF_MAX_WINDOW  = 7;

  typedef struct packed {
    logic               opcode;
    logic [POS_W-1:0]   load_row;
    logic [POS_W-1:0]   load_col;
    logic [VAL_W-1:0]   entry_value;
    logic [RES_W-1:0]   first_residue;
    logic [RES_W-1:0]   second_residue;
  } in_item_t;

  typedef struct packed {
    logic               passes;
    logic [CNT_W-1:0]   window_count;
  } out_item_t;

  typedef struct packed {
    logic [CUTOFF_W-1:0] count_cutoff;
    logic [WS_W-1:0]     window_size;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

@@ src/window_sum_threshold_2d_core.sv @@
// top level of the clipped window sum threshold block
// depends on wst2d_pkg, wst2d_regs, wst2d_window
//
// channel  direction  handshake                  payload
// in       request    in_valid_i / in_stall_o    in_item_i  (in_item_t)
// out      result     out_valid_o / out_stall_i  out_item_o (out_item_t)
// cfg      write/read psel penable pwrite pready paddr pwdata prdata
//
// a load is written to the matrix at its accept edge
// a query walks every window position, h = min(window_size, MAX_WINDOW), one position
// per cycle (clipped ones too) on the single matrix read port
// rst_ni clears control state only; matrix contents stay undefined until loaded
// the result register holds while out_stall_i is high; loads and a new query
// are still taken, and a finished query waits for the register to free up
`default_nettype none

module window_sum_threshold_2d_core
  import wst2d_pkg::*;
#(
  parameter int MATRIX_SIZE = DEF_MATRIX_SIZE,
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t      cfg;
  res_t      res;
  logic      busy;
  logic      take;
  logic      slot_free;
  logic      out_valid_q;
  out_item_t out_item_q;

  wst2d_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign take      = in_valid_i & !busy;
  assign slot_free = !out_valid_q | !out_stall_i;

  wst2d_window #(
    .MATRIX_SIZE (MATRIX_SIZE),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (in_item_i),
    .cfg_i       (cfg),
    .slot_free_i (slot_free),
    .busy_o      (busy),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_item_q <= res.item;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ src/wst2d_regs.sv @@
// configuration registers behind the apb-style port
// depends on wst2d_pkg
`default_nettype none

module wst2d_regs
  import wst2d_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [CUTOFF_W-1:0]  cutoff_q;
  logic [WS_W-1:0]      ws_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      ws_q     <= WS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_COUNT_CUTOFF: cutoff_q <= pwdata[CUTOFF_W-1:0];
        REG_WINDOW_SIZE:  ws_q     <= pwdata[WS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT_CUTOFF: prdata = DATA_W'(cutoff_q);
      REG_WINDOW_SIZE:  prdata = DATA_W'(ws_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.count_cutoff = cutoff_q;
  assign cfg_o.window_size  = ws_q;

endmodule

`default_nettype wire

@@ src/wst2d_window.sv @@
// count matrix memory with the window sequencer and the shared accumulator
// depends on wst2d_pkg
`default_nettype none

module wst2d_window
  import wst2d_pkg::*;
#(
  parameter int MATRIX_SIZE = DEF_MATRIX_SIZE,
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     take_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  input  wire logic     slot_free_i,
  output logic          busy_o,
  output res_t          res_o
);

  localparam int IDX_W  = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int CRD_W  = (IDX_W + 2 > RES_W + 2) ? IDX_W + 2 : RES_W + 2;
  localparam int DEPTH  = 1 << (2 * IDX_W);
  localparam int OFS_W  = WS_W + 1;
  localparam int WS_MAX = (1 << WS_W) - 1;
  localparam int WIN_LIM = (MAX_WINDOW < WS_MAX) ? MAX_WINDOW : WS_MAX;
  localparam logic signed [CRD_W-1:0] MS_C = CRD_W'(MATRIX_SIZE);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic signed [CRD_W-1:0] crow_q, ccol_q;
  logic signed [OFS_W-1:0] dr_q, dc_q;
  logic [WS_W-1:0]         half_q, half_d;
  logic signed [OFS_W-1:0] half_s, half_n;
  logic signed [CRD_W-1:0] r, c;
  logic                    in_win;
  logic                    rv_q;
  logic [VAL_W-1:0]        rd_q;
  logic [CNT_W-1:0]        acc_q;
  logic [CNT_W:0]          sum;
  logic                    start, ld_en;
  logic [CRD_W-1:0]        ld_row, ld_col;

  logic [VAL_W-1:0] mem_q [DEPTH];

  assign start  = take_i & (item_i.opcode == OP_QUERY);
  assign ld_row = CRD_W'(item_i.load_row);
  assign ld_col = CRD_W'(item_i.load_col);
  assign ld_en  = take_i & (item_i.opcode == OP_LOAD) &
                  (ld_row < CRD_W'(MATRIX_SIZE)) & (ld_col < CRD_W'(MATRIX_SIZE));

  // window half-width, clamped to the build limit
  assign half_d = ({29'b0, cfg_i.window_size} > WIN_LIM) ? WS_W'(WIN_LIM)
                                                          : cfg_i.window_size;
  assign half_s = $signed({1'b0, half_q});
  assign half_n = -half_s;

  assign r      = crow_q + CRD_W'(dr_q);
  assign c      = ccol_q + CRD_W'(dc_q);
  assign in_win = (state_q == S_RUN) & !r[CRD_W-1] & !c[CRD_W-1] &
                  (r < MS_C) & (c < MS_C);

  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      mem_q[{ld_row[IDX_W-1:0], ld_col[IDX_W-1:0]}] <= item_i.entry_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_win) begin
      rd_q <= mem_q[{r[IDX_W-1:0], c[IDX_W-1:0]}];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_RUN;
      S_RUN:   if (dc_q == half_s && dr_q == half_s) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  if (slot_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= in_win;
    end
  end

  // walk columns inside rows, one window position a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      crow_q <= CRD_W'(item_i.first_residue) - CRD_W'(1);
      ccol_q <= CRD_W'(item_i.second_residue) - CRD_W'(1);
      half_q <= half_d;
      dr_q   <= -$signed({1'b0, half_d});
      dc_q   <= -$signed({1'b0, half_d});
    end else if (state_q == S_RUN) begin
      if (dc_q == half_s) begin
        dc_q <= half_n;
        dr_q <= dr_q + OFS_W'(1);
      end else begin
        dc_q <= dc_q + OFS_W'(1);
      end
    end
  end

  assign sum = {1'b0, acc_q} + (CNT_W + 1)'(rd_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      acc_q <= '0;
    end else if (rv_q) begin
      acc_q <= sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    end
  end

  assign busy_o                  = (state_q != S_IDLE);
  assign res_o.valid             = (state_q == S_DONE) & slot_free_i;
  assign res_o.item.window_count = acc_q;
  assign res_o.item.passes       = (acc_q >= cfg_i.count_cutoff);

endmodule

`default_nettype wire

@@ src/wst2d_checker.sv @@
// port-level checks for the window sum threshold block, with its bind
// depends on wst2d_pkg and window_sum_threshold_2d_core
`default_nettype none

module wst2d_port_checks
  import wst2d_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i
);

  logic in_take;
  assign in_take = in_valid_i & !in_stall_o;

  // a held result stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a query request locks the input side while it runs
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_item_i.opcode == OP_QUERY) |=> in_stall_o)
    else $error("input open right after query request");

  // a load request never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_item_i.opcode == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("result after load request");

  // a new result only comes out of a running query
  a_res_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query in progress");

endmodule

bind window_sum_threshold_2d_core wst2d_port_checks u_wst2d_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
